@@ rtl/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants, types and functions of the planar pose transform unit.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int CORDIC_FRAC       = 30;
	localparam int ATAN_LEN          = 24;
	localparam int CW                = 34;   // cordic datapath width
	localparam int ZW                = 33;   // cordic angle width

	localparam logic [2:0] CMD_APPLY     = 3'd0;
	localparam logic [2:0] CMD_FROM_MOVE = 3'd1;
	localparam logic [2:0] CMD_BACK      = 3'd2;
	localparam logic [2:0] CMD_BACK_MOVE = 3'd3;
	localparam logic [2:0] CMD_BETWEEN   = 3'd4;
	localparam logic [2:0] CMD_NONE      = 3'd7;   // any unused command

	localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [15:0] bh;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [15:0] oh;
	} pose_req_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] heading;
		logic               sat;
	} pose_res_t;

	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 33'sh020000000;
			1:  r = 33'sh012E4051E;
			2:  r = 33'sh009FB385B;
			3:  r = 33'sh0051111D4;
			4:  r = 33'sh0028B0D43;
			5:  r = 33'sh00145D7E1;
			6:  r = 33'sh000A2F61E;
			7:  r = 33'sh000517C55;
			8:  r = 33'sh00028BE53;
			9:  r = 33'sh000145F2F;
			10: r = 33'sh0000A2F98;
			11: r = 33'sh0000517CC;
			12: r = 33'sh000028BE6;
			13: r = 33'sh0000145F3;
			14: r = 33'sh00000A2FA;
			15: r = 33'sh00000517D;
			16: r = 33'sh0000028BE;
			17: r = 33'sh00000145F;
			18: r = 33'sh000000A30;
			19: r = 33'sh000000518;
			20: r = 33'sh00000028C;
			21: r = 33'sh000000146;
			22: r = 33'sh0000000A3;
			23: r = 33'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/ppt_stream_if.sv @@
// ----------------------------------------------------------------------------
// ppt_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface ppt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ppt_cordic.sv @@
// ----------------------------------------------------------------------------
// ppt_cordic
// Pipelined rotation-mode CORDIC, one iteration per stage, with a sideband
// carried along. Emits cosine and sine rounded to FRAC_BITS and clamped.
// ----------------------------------------------------------------------------
module ppt_cordic #(
	parameter int STAGES    = ppt_pkg::CORDIC_STAGES_DEF,
	parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF,
	parameter int SBW       = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [15:0]      angle,
	input  logic [SBW-1:0]          in_side,
	output logic                    out_valid,
	output logic signed [FRAC_BITS+1:0] cos_o,
	output logic signed [FRAC_BITS+1:0] sin_o,
	output logic [SBW-1:0]          out_side
);
	localparam int CW = ppt_pkg::CW;
	localparam int ZW = ppt_pkg::ZW;
	localparam int N  = (STAGES < ppt_pkg::ATAN_LEN) ? STAGES : ppt_pkg::ATAN_LEN;
	localparam int SH = ppt_pkg::CORDIC_FRAC - FRAC_BITS;
	localparam int OW = FRAC_BITS + 2;

	logic signed [CW-1:0] x_q [0:N];
	logic signed [CW-1:0] y_q [0:N];
	logic signed [ZW-1:0] z_q [0:N];
	logic                 neg_q [0:N];
	logic                 v_q [0:N];
	logic [SBW-1:0]       sd_q [0:N];

	logic signed [ZW-1:0] z0;
	logic signed [ZW-1:0] zf;
	logic                 fold;

	always_comb begin
		z0   = ZW'(angle) <<< 16;
		fold = (z0 > (ZW'(1) <<< 30)) || (z0 < -(ZW'(1) <<< 30));
		if (!fold)
			zf = z0;
		else if (z0 > 0)
			zf = z0 - (ZW'(1) <<< 31);
		else
			zf = z0 + (ZW'(1) <<< 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q[0] <= 1'b0;
		else if (en)
			v_q[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]   <= ppt_pkg::INV_GAIN;
			y_q[0]   <= '0;
			z_q[0]   <= zf;
			neg_q[0] <= fold;
			sd_q[0]  <= in_side;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[i+1] <= 1'b0;
			else if (en)
				v_q[i+1] <= v_q[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - ppt_pkg::atan_turn(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + ppt_pkg::atan_turn(i);
				end
				neg_q[i+1] <= neg_q[i];
				sd_q[i+1]  <= sd_q[i];
			end
		end
	end

	// round half up, clamp to +-1.0, undo the fold
	function automatic logic signed [OW-1:0] fin(input logic signed [CW-1:0] v,
		input logic neg);
		logic signed [CW-1:0] r;
		logic signed [CW-1:0] one;
		begin
			one = CW'(1) <<< FRAC_BITS;
			r   = (v + (CW'(1) <<< (SH - 1))) >>> SH;
			if (r > one)
				r = one;
			if (r < -one)
				r = -one;
			if (neg)
				r = -r;
			return OW'(r);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_q[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o    <= fin(x_q[N], neg_q[N]);
			sin_o    <= fin(y_q[N], neg_q[N]);
			out_side <= sd_q[N];
		end
	end

endmodule

@@ rtl/ppt_combine.sv @@
// ----------------------------------------------------------------------------
// ppt_combine
// Multiply, sum, round and saturate stages that build the result pose from
// the sine, cosine and the operands.
// ----------------------------------------------------------------------------
module ppt_combine #(
	parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  ppt_pkg::pose_req_t          req,
	input  logic signed [15:0]          head,
	input  logic signed [FRAC_BITS+1:0] c,
	input  logic signed [FRAC_BITS+1:0] s,
	output logic                        out_valid,
	output ppt_pkg::pose_res_t          res
);
	localparam int PW = 34 + FRAC_BITS + 2;
	localparam int AW = PW + 3;

	// stage 1: operand select
	logic signed [32:0] ma_s1, mb_s1;
	logic signed [FRAC_BITS+1:0] c_s1, s_s1;
	logic signed [AW-1:0] base_x_s1, base_y_s1;
	logic [2:0] cmd_s1;
	logic signed [15:0] h_s1;
	logic signed [31:0] ox_s1;
	logic v_s1;

	// stage 2: products
	logic signed [PW-1:0] p_cf_s2, p_sw_s2, p_sf_s2, p_cw_s2;
	logic signed [AW-1:0] base_x_s2, base_y_s2;
	logic [2:0] cmd_s2;
	logic signed [15:0] h_s2;
	logic signed [31:0] ox_s2;
	logic v_s2;

	// stage 3: sums
	logic signed [AW-1:0] ax_s3, ay_s3;
	logic [2:0] cmd_s3;
	logic signed [15:0] h_s3;
	logic signed [31:0] ox_s3;
	logic v_s3;

	logic signed [AW-1:0] rx, ry;
	logic sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (req.cmd)
				ppt_pkg::CMD_BETWEEN: begin
					ma_s1 <= 33'(req.ox) - 33'(req.bx);
					mb_s1 <= 33'(req.oy) - 33'(req.by);
					base_x_s1 <= '0;
					base_y_s1 <= '0;
				end
				ppt_pkg::CMD_BACK_MOVE: begin
					ma_s1 <= 33'(req.ox);
					mb_s1 <= 33'(req.oy);
					base_x_s1 <= '0;
					base_y_s1 <= '0;
				end
				ppt_pkg::CMD_FROM_MOVE: begin
					// carry the sideward move so that it can be negated later
					ma_s1 <= 33'(req.ox);
					mb_s1 <= 33'(req.oy);
					base_x_s1 <= '0;
					base_y_s1 <= AW'(req.oy) <<< FRAC_BITS;
				end
				default: begin
					ma_s1 <= 33'(req.ox);
					mb_s1 <= 33'(req.oy);
					base_x_s1 <= AW'(req.bx) <<< FRAC_BITS;
					base_y_s1 <= AW'(req.by) <<< FRAC_BITS;
				end
			endcase
			c_s1   <= c;
			s_s1   <= s;
			cmd_s1 <= req.cmd;
			h_s1   <= head;
			ox_s1  <= req.ox;

			p_cf_s2 <= PW'(c_s1) * PW'(ma_s1);
			p_sw_s2 <= PW'(s_s1) * PW'(mb_s1);
			p_sf_s2 <= PW'(s_s1) * PW'(ma_s1);
			p_cw_s2 <= PW'(c_s1) * PW'(mb_s1);
			base_x_s2 <= base_x_s1;
			base_y_s2 <= base_y_s1;
			cmd_s2 <= cmd_s1;
			h_s2   <= h_s1;
			ox_s2  <= ox_s1;

			case (cmd_s2)
				ppt_pkg::CMD_APPLY, ppt_pkg::CMD_BETWEEN: begin
					ax_s3 <= base_x_s2 + AW'(p_cf_s2) + AW'(p_sw_s2);
					ay_s3 <= base_y_s2 + AW'(p_sf_s2) - AW'(p_cw_s2);
				end
				ppt_pkg::CMD_BACK, ppt_pkg::CMD_BACK_MOVE: begin
					ax_s3 <= base_x_s2 - AW'(p_cf_s2) - AW'(p_sw_s2);
					ay_s3 <= base_y_s2 - AW'(p_sf_s2) + AW'(p_cw_s2);
				end
				ppt_pkg::CMD_FROM_MOVE: begin
					ax_s3 <= '0;
					ay_s3 <= -base_y_s2;
				end
				default: begin
					ax_s3 <= '0;
					ay_s3 <= '0;
				end
			endcase
			cmd_s3 <= cmd_s2;
			h_s3   <= h_s2;
			ox_s3  <= ox_s2;
		end
	end

	always_comb begin
		rx = (ax_s3 + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		ry = (ay_s3 + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		sx = (rx > AW'(32'sh7FFFFFFF)) || (rx < -(AW'(1) <<< 31));
		sy = (ry > AW'(32'sh7FFFFFFF)) || (ry < -(AW'(1) <<< 31));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cmd_s3 == ppt_pkg::CMD_FROM_MOVE)
				res.x <= ox_s3;
			else if (rx > AW'(32'sh7FFFFFFF))
				res.x <= 32'sh7FFFFFFF;
			else if (sx)
				res.x <= 32'sh80000000;
			else
				res.x <= rx[31:0];
			if (ry > AW'(32'sh7FFFFFFF))
				res.y <= 32'sh7FFFFFFF;
			else if (sy)
				res.y <= 32'sh80000000;
			else
				res.y <= ry[31:0];
			res.heading <= h_s3;
			res.sat <= (sx && (cmd_s3 != ppt_pkg::CMD_FROM_MOVE)) || sy;
		end
	end

endmodule

@@ rtl/planar_pose_transform_unit.sv @@
// ----------------------------------------------------------------------------
// planar_pose_transform_unit
// SE(2) pose composition: apply, invert and relate planar poses.
// ----------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled, and its result
// passes through the CORDIC pipeline (an input register, one stage per
// iteration and an output register) followed by the select, multiply, sum
// and round stages. The whole pipeline advances together when the output
// register is empty or being taken, so a stall on the output holds every
// stage and loses no item.
module planar_pose_transform_unit #(
	parameter int CORDIC_STAGES = ppt_pkg::CORDIC_STAGES_DEF,
	parameter int FRAC_BITS     = ppt_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	ppt_stream_if.sink   req,
	ppt_stream_if.source res
);
	localparam int SBW = $bits(ppt_pkg::pose_req_t) + 16;

	logic en;
	ppt_pkg::pose_req_t r_in, r_mid;
	logic signed [15:0] ang, head_mid;
	logic [SBW-1:0] side_o;
	logic cv;
	logic signed [FRAC_BITS+1:0] c, s;
	logic ov;
	ppt_pkg::pose_res_t rr;

	// the last register doubles as the output register
	assign en = !res.valid || res.ready;
	assign req.ready = en;
	assign res.valid = ov;
	assign res.data = rr;

	always_comb begin
		r_in = req.data;
		case (r_in.cmd)
			ppt_pkg::CMD_APPLY:     ang = r_in.bh + r_in.oh;
			ppt_pkg::CMD_FROM_MOVE: ang = r_in.oh;
			ppt_pkg::CMD_BACK:      ang = r_in.bh - r_in.oh;
			ppt_pkg::CMD_BACK_MOVE: ang = -r_in.oh;
			ppt_pkg::CMD_BETWEEN:   ang = r_in.oh - r_in.bh;
			default:                ang = '0;
		endcase
		if (r_in.cmd > ppt_pkg::CMD_BETWEEN)
			r_in.cmd = ppt_pkg::CMD_NONE;
	end

	// the cordic angle is the base heading for forward commands
	logic signed [15:0] cang;
	always_comb begin
		if (r_in.cmd == ppt_pkg::CMD_BACK || r_in.cmd == ppt_pkg::CMD_BACK_MOVE)
			cang = ang;
		else
			cang = r_in.bh;
	end

	ppt_cordic #(
		.STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS), .SBW(SBW)
	) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(req.valid), .angle(cang), .in_side({r_in, ang}),
		.out_valid(cv), .cos_o(c), .sin_o(s), .out_side(side_o)
	);

	always_comb begin
		{r_mid, head_mid} = side_o;
		if (r_mid.cmd == ppt_pkg::CMD_NONE)
			head_mid = '0;
	end

	ppt_combine #(.FRAC_BITS(FRAC_BITS)) u_comb (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(cv), .req(r_mid), .head(head_mid), .c(c), .s(s),
		.out_valid(ov), .res(rr)
	);

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!res.valid || res.ready))
		else $error("ready does not follow output stall");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.sat |-> res.data.x == 32'sh7FFFFFFF
		|| res.data.x == 32'sh80000000 || res.data.y == 32'sh7FFFFFFF
		|| res.data.y == 32'sh80000000)
		else $error("saturated flag without a clamped position");
`endif

endmodule
